[rtl/core/mse_pkg.sv]
// Shared types, opcodes and constants for the MIPS subset executor
`timescale 1ns / 1ps
package mse_pkg;
	localparam int unsigned DATA_WORDS_DEF = 1024;
	localparam logic [31:0] START_PC_RST = 32'h0040_0000;
	localparam logic [31:0] DATA_BASE_RST = 32'h1000_0000;
	localparam logic [31:0] PC_HI_MASK = 32'hf000_0000;
	localparam logic [31:0] LO_MASK = 32'h0000_ffff;
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [5:0] {
		OP_SPECIAL = 6'h00, OP_J = 6'h02, OP_JAL = 6'h03, OP_BEQ = 6'h04,
		OP_BNE = 6'h05, OP_ADDIU = 6'h09, OP_SLTIU = 6'h0b, OP_ANDI = 6'h0c,
		OP_ORI = 6'h0d, OP_LUI = 6'h0f, OP_LW = 6'h23, OP_SW = 6'h2b
	} opcode_t;

	typedef enum logic [5:0] {
		FN_SLL = 6'h00, FN_SRL = 6'h02, FN_JR = 6'h08, FN_ADDU = 6'h21,
		FN_SUBU = 6'h23, FN_AND = 6'h24, FN_OR = 6'h25, FN_NOR = 6'h27,
		FN_SLTU = 6'h2b
	} funct_t;

	typedef enum logic [3:0] {
		K_NOP, K_HALT, K_PRELOAD, K_ADDU, K_SUBU, K_AND, K_OR, K_NOR, K_SLTU,
		K_SLL, K_SRL, K_JR, K_J, K_JAL, K_BEQ, K_BNE
	} kind_t;

	typedef enum logic [2:0] {
		I_NONE, I_ADDIU, I_ANDI, I_ORI, I_SLTIU, I_LUI, I_LW, I_SW
	} ikind_t;

	localparam int unsigned CFG_START_PC = 0;
	localparam int unsigned CFG_DATA_BASE = 1;

	typedef struct packed {
		kind_t kind;
		ikind_t ikind;
		logic [4:0] rs;
		logic [4:0] rt;
		logic [4:0] dst;
		logic [4:0] sh;
		logic [15:0] imm;
		logic [25:0] target;
		logic [9:0] pl_index;
		logic [31:0] pl_value;
	} uop_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic halted;
		logic reg_written;
		logic [4:0] reg_index;
		logic [31:0] reg_value;
		logic mem_written;
		logic [31:0] mem_address;
		logic [31:0] mem_value;
	} res_t;
endpackage

[rtl/core/mse_if.sv]
// Valid/ready channel interfaces for items and results
`timescale 1ns / 1ps
interface mse_in_if;
	logic valid;
	logic ready;
	logic action;
	logic [31:0] instr_word;
	logic [9:0] preload_index;
	logic [31:0] preload_value;
	modport source(output valid, action, instr_word, preload_index, preload_value,
		input ready);
	modport sink(input valid, action, instr_word, preload_index, preload_value,
		output ready);
endinterface

interface mse_out_if;
	logic valid;
	logic ready;
	logic [31:0] next_pc;
	logic halted;
	logic reg_written;
	logic [4:0] reg_index;
	logic [31:0] reg_value;
	logic mem_written;
	logic [31:0] mem_address;
	logic [31:0] mem_value;
	modport source(output valid, next_pc, halted, reg_written, reg_index, reg_value,
		mem_written, mem_address, mem_value, input ready);
	modport sink(input valid, next_pc, halted, reg_written, reg_index, reg_value,
		mem_written, mem_address, mem_value, output ready);
endinterface

[rtl/core/mips_subset_executor.sv]
// Top level of the MIPS subset executor
// An accepted item's operands are registered in the register file and data
// memory read phase; its result is registered in the execute and write-back
// phase, which waits for a free output. No new item is taken before it ends.
// A two-entry decode queue and the result register keep input and output apart.
// Reset: pc to start_pc, registers zero, halt cleared; data memory is not cleared.
`timescale 1ns / 1ps
module mips_subset_executor #(
	parameter int unsigned DATA_WORDS = mse_pkg::DATA_WORDS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [31:0] cfg_data,
	mse_in_if.sink in_ch,
	mse_out_if.source out_ch
);
	logic uop_valid, uop_ready;
	mse_pkg::uop_t uop;

	mse_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.uop_valid(uop_valid), .uop_ready(uop_ready), .uop(uop)
	);

	mse_back #(.DATA_WORDS(DATA_WORDS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.uop_valid(uop_valid), .uop_ready(uop_ready), .uop(uop),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_ch(out_ch)
	);
endmodule

[rtl/core/mse_front.sv]
// Front end: accepts items, decodes them into micro-ops and queues them
`timescale 1ns / 1ps
module mse_front (
	input  logic clk,
	input  logic arst_n,
	mse_in_if.sink in_ch,
	output logic uop_valid,
	input  logic uop_ready,
	output mse_pkg::uop_t uop
);
	localparam int unsigned PW = $clog2(mse_pkg::QUEUE_DEPTH);

	mse_pkg::uop_t dec;
	mse_pkg::uop_t queue_q [mse_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0] count_q;
	logic push, pop;
	logic [5:0] op, fn;

	assign op = in_ch.instr_word[31:26];
	assign fn = in_ch.instr_word[5:0];

	always_comb begin
		dec = '0;
		dec.kind = mse_pkg::K_NOP;
		dec.ikind = mse_pkg::I_NONE;
		dec.rs = in_ch.instr_word[25:21];
		dec.rt = in_ch.instr_word[20:16];
		dec.dst = in_ch.instr_word[15:11];
		dec.sh = in_ch.instr_word[10:6];
		dec.imm = in_ch.instr_word[15:0];
		dec.target = in_ch.instr_word[25:0];
		dec.pl_index = in_ch.preload_index;
		dec.pl_value = in_ch.preload_value;
		if (in_ch.action) begin
			dec.kind = mse_pkg::K_PRELOAD;
		end else if (in_ch.instr_word == 32'h0) begin
			dec.kind = mse_pkg::K_HALT;
		end else if (op == mse_pkg::OP_SPECIAL) begin
			unique case (fn)
				mse_pkg::FN_ADDU: dec.kind = mse_pkg::K_ADDU;
				mse_pkg::FN_SUBU: dec.kind = mse_pkg::K_SUBU;
				mse_pkg::FN_AND:  dec.kind = mse_pkg::K_AND;
				mse_pkg::FN_OR:   dec.kind = mse_pkg::K_OR;
				mse_pkg::FN_NOR:  dec.kind = mse_pkg::K_NOR;
				mse_pkg::FN_SLTU: dec.kind = mse_pkg::K_SLTU;
				mse_pkg::FN_SLL:  dec.kind = mse_pkg::K_SLL;
				mse_pkg::FN_SRL:  dec.kind = mse_pkg::K_SRL;
				mse_pkg::FN_JR:   dec.kind = mse_pkg::K_JR;
				default:          dec.kind = mse_pkg::K_NOP;
			endcase
		end else begin
			dec.dst = in_ch.instr_word[20:16];
			unique case (op)
				mse_pkg::OP_J:     dec.kind = mse_pkg::K_J;
				mse_pkg::OP_JAL: begin
					dec.kind = mse_pkg::K_JAL;
					dec.dst = 5'd31;
				end
				mse_pkg::OP_BEQ:   dec.kind = mse_pkg::K_BEQ;
				mse_pkg::OP_BNE:   dec.kind = mse_pkg::K_BNE;
				mse_pkg::OP_ADDIU: dec.ikind = mse_pkg::I_ADDIU;
				mse_pkg::OP_ANDI:  dec.ikind = mse_pkg::I_ANDI;
				mse_pkg::OP_ORI:   dec.ikind = mse_pkg::I_ORI;
				mse_pkg::OP_SLTIU: dec.ikind = mse_pkg::I_SLTIU;
				mse_pkg::OP_LUI:   dec.ikind = mse_pkg::I_LUI;
				mse_pkg::OP_LW:    dec.ikind = mse_pkg::I_LW;
				mse_pkg::OP_SW:    dec.ikind = mse_pkg::I_SW;
				default:           dec.kind = mse_pkg::K_NOP;
			endcase
		end
	end

	assign in_ch.ready = (count_q != (PW+1)'(mse_pkg::QUEUE_DEPTH));
	assign push = in_ch.valid && in_ch.ready;
	assign uop_valid = (count_q != '0);
	assign pop = uop_valid && uop_ready;
	assign uop = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) queue_q[wr_ptr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PW+1)'(mse_pkg::QUEUE_DEPTH))
		else $error("queue overfilled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count lost a push");
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> !pop)
		else $error("pop from empty queue");
endmodule

[rtl/core/mse_back.sv]
// Back end: register read, execute, data memory access and result register
`timescale 1ns / 1ps
module mse_back #(
	parameter int unsigned DATA_WORDS = mse_pkg::DATA_WORDS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic uop_valid,
	output logic uop_ready,
	input  mse_pkg::uop_t uop,
	input  logic cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [31:0] cfg_data,
	mse_out_if.source out_ch
);
	localparam int unsigned AW = $clog2(DATA_WORDS);

	typedef enum logic [0:0] { PH_READ, PH_EXEC } phase_t;

	phase_t phase_q;
	logic [31:0] pc_q, base_q;
	logic stopped_q;
	logic [31:0] rf_q [32];
	logic [31:0] dmem [DATA_WORDS];
	logic [31:0] a_s1, b_s1, ld_s1;
	mse_pkg::uop_t u_s1;
	mse_pkg::res_t res_q, res;
	logic res_valid_q;
	logic [31:0] simm, zimm, pc4, ea, wval, npc;
	logic wen, sten;
	logic [AW-1:0] ld_idx, st_idx;
	logic take, fire, out_free;

	assign out_free = !res_valid_q || out_ch.ready;
	assign take = (phase_q == PH_READ) && uop_valid;
	assign uop_ready = take;
	assign fire = (phase_q == PH_EXEC) && out_free;

	assign simm = {{16{u_s1.imm[15]}}, u_s1.imm};
	assign zimm = {16'h0, u_s1.imm} & mse_pkg::LO_MASK;
	assign pc4 = pc_q + 32'd4;
	assign ea = a_s1 + simm;

	always_comb begin
		logic [31:0] ra, ri;
		logic [31:0] off;
		ra = rf_q[uop.rs];
		ri = ra + {{16{uop.imm[15]}}, uop.imm} - base_q;
		off = ri;
		ld_idx = AW'(off[31:2]);
	end

	always_comb begin
		wen = 1'b0;
		sten = 1'b0;
		wval = '0;
		npc = pc4;
		unique case (u_s1.kind)
			mse_pkg::K_ADDU: begin wen = 1'b1; wval = a_s1 + b_s1; end
			mse_pkg::K_SUBU: begin wen = 1'b1; wval = a_s1 - b_s1; end
			mse_pkg::K_AND:  begin wen = 1'b1; wval = a_s1 & b_s1; end
			mse_pkg::K_OR:   begin wen = 1'b1; wval = a_s1 | b_s1; end
			mse_pkg::K_NOR:  begin wen = 1'b1; wval = ~(a_s1 | b_s1); end
			mse_pkg::K_SLTU: begin wen = 1'b1; wval = {31'h0, a_s1 < b_s1}; end
			mse_pkg::K_SLL:  begin wen = 1'b1; wval = b_s1 << u_s1.sh; end
			mse_pkg::K_SRL:  begin wen = 1'b1; wval = b_s1 >> u_s1.sh; end
			mse_pkg::K_JR:   npc = a_s1;
			mse_pkg::K_J:    npc = (pc4 & mse_pkg::PC_HI_MASK) | {4'h0, u_s1.target, 2'b00};
			mse_pkg::K_JAL: begin
				wen = 1'b1;
				wval = pc4;
				npc = (pc4 & mse_pkg::PC_HI_MASK) | {4'h0, u_s1.target, 2'b00};
			end
			mse_pkg::K_BEQ: if (a_s1 == b_s1) npc = pc4 + {simm[29:0], 2'b00};
			mse_pkg::K_BNE: if (a_s1 != b_s1) npc = pc4 + {simm[29:0], 2'b00};
			mse_pkg::K_HALT:    npc = pc_q;
			mse_pkg::K_PRELOAD: npc = pc_q;
			default: begin
				unique case (u_s1.ikind)
					mse_pkg::I_ADDIU: begin wen = 1'b1; wval = ea; end
					mse_pkg::I_ANDI:  begin wen = 1'b1; wval = a_s1 & zimm; end
					mse_pkg::I_ORI:   begin wen = 1'b1; wval = a_s1 | zimm; end
					mse_pkg::I_SLTIU: begin wen = 1'b1; wval = {31'h0, a_s1 < simm}; end
					mse_pkg::I_LUI:   begin wen = 1'b1; wval = {u_s1.imm, 16'h0}; end
					mse_pkg::I_LW:    begin wen = 1'b1; wval = ld_s1; end
					mse_pkg::I_SW:    sten = 1'b1;
					default: ;
				endcase
			end
		endcase
		if (u_s1.dst == 5'd0) wen = 1'b0;
		if (stopped_q) begin
			wen = 1'b0;
			sten = 1'b0;
			npc = pc_q;
		end
	end

	always_comb begin
		logic [31:0] off;
		off = ea - base_q;
		st_idx = AW'(off[31:2]);
	end

	always_comb begin
		res = '0;
		res.next_pc = npc;
		res.halted = stopped_q || (u_s1.kind == mse_pkg::K_HALT);
		res.reg_written = wen;
		res.reg_index = wen ? u_s1.dst : 5'd0;
		res.reg_value = wen ? wval : 32'h0;
		res.mem_written = sten;
		res.mem_address = sten ? ea : 32'h0;
		res.mem_value = sten ? b_s1 : 32'h0;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			u_s1 <= uop;
			a_s1 <= rf_q[uop.rs];
			b_s1 <= rf_q[uop.rt];
			ld_s1 <= dmem[ld_idx];
		end
		if (fire) begin
			res_q <= res;
			if (sten) dmem[st_idx] <= b_s1;
			else if (!stopped_q && u_s1.kind == mse_pkg::K_PRELOAD)
				dmem[AW'(u_s1.pl_index)] <= u_s1.pl_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_READ;
			pc_q <= mse_pkg::START_PC_RST;
			base_q <= mse_pkg::DATA_BASE_RST;
			stopped_q <= 1'b0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < 32; i++) rf_q[i] <= '0;
		end else begin
			if (out_ch.valid && out_ch.ready) res_valid_q <= 1'b0;
			if (take) phase_q <= PH_EXEC;
			if (fire) begin
				phase_q <= PH_READ;
				res_valid_q <= 1'b1;
				pc_q <= npc;
				if (u_s1.kind == mse_pkg::K_HALT) stopped_q <= 1'b1;
				if (wen) rf_q[u_s1.dst] <= wval;
			end
			if (cfg_we) begin
				if (cfg_index == 1'(mse_pkg::CFG_START_PC)) pc_q <= cfg_data;
				else base_q <= cfg_data;
			end
		end
	end

	assign out_ch.valid = res_valid_q;
	assign out_ch.next_pc = res_q.next_pc;
	assign out_ch.halted = res_q.halted;
	assign out_ch.reg_written = res_q.reg_written;
	assign out_ch.reg_index = res_q.reg_index;
	assign out_ch.reg_value = res_q.reg_value;
	assign out_ch.mem_written = res_q.mem_written;
	assign out_ch.mem_address = res_q.mem_address;
	assign out_ch.mem_value = res_q.mem_value;

	assert property (@(posedge clk) disable iff (!arst_n)
		$past(stopped_q) |-> stopped_q)
		else $error("halt flag cleared");
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && stopped_q) |=> (res_valid_q && res_q.halted && !res_q.reg_written
			&& !res_q.mem_written))
		else $error("write reported while halted");
	assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !fire)
		else $error("read and execute overlap");
endmodule
